// File: src/alist_pkg.sv
`timescale 1ns / 1ps

package alist_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_DEL_POS = 3'd2,
        ACT_DEL_VAL = 3'd3,
        ACT_SEARCH  = 3'd4,
        ACT_DISPLAY = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_GET,
        S_GOT,
        S_DN_RD,
        S_DN_WR,
        S_SC_RD,
        S_SC_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [VAL_W-1:0] item_value;
        logic [CNT_W-1:0]        item_position;
    } t_in_word;

    typedef struct packed {
        logic [2:0]              status;
        logic [IDX_W-1:0]        found_position;
        logic signed [VAL_W-1:0] entry_value;
        logic [CNT_W-1:0]        fill_count;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: src/alist_ram.sv
`timescale 1ns / 1ps

module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/alist_ctrl.sv
`timescale 1ns / 1ps

module alist_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  alist_pkg::t_in_word                    i_in_word,
    output logic                                   o_in_ready,
    input  logic                                   i_slot_free,
    output logic                                   o_emit,
    output alist_pkg::t_out_word                   o_emit_word,
    output alist_pkg::t_ram_req                    o_ram_req,
    input  logic [alist_pkg::VAL_W-1:0]            i_ram_rdata
);

    alist_pkg::t_state                r_state, n_state;
    logic [alist_pkg::CNT_W-1:0]      r_count, n_count;
    logic [2:0]                       r_act, n_act;
    logic [alist_pkg::VAL_W-1:0]      r_val, n_val;
    logic [alist_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [alist_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                             r_pend, n_pend;
    logic [alist_pkg::IDX_W-1:0]      r_pend_pos, n_pend_pos;
    alist_pkg::t_status               r_st, n_st;
    logic [alist_pkg::IDX_W-1:0]      r_rpos, n_rpos;
    logic [alist_pkg::VAL_W-1:0]      r_rval, n_rval;

    logic [alist_pkg::CNT_W-1:0]      idx_dn;
    logic [alist_pkg::CNT_W-1:0]      idx_up;
    logic                             hit;
    logic                             disp_last;

    assign idx_dn    = r_idx - alist_pkg::CNT_W'(1);
    assign idx_up    = r_idx + alist_pkg::CNT_W'(1);
    assign hit       = (i_ram_rdata == r_val);
    assign disp_last = (idx_up == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alist_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_pend_pos <= n_pend_pos;
        r_st       <= n_st;
        r_rpos     <= n_rpos;
        r_rval     <= n_rval;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_act       = r_act;
        n_val       = r_val;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_pos  = r_pend_pos;
        n_st        = r_st;
        n_rpos      = r_rpos;
        n_rval      = r_rval;
        o_in_ready  = 1'b0;
        o_emit      = 1'b0;
        o_emit_word = '0;
        o_ram_req   = '0;

        case (r_state)
            alist_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act  = i_in_word.action;
                    n_val  = i_in_word.item_value;
                    n_pos  = i_in_word.item_position;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_st   = alist_pkg::ST_OK;
                    n_rpos = '0;
                    n_rval = i_in_word.item_value;
                    case (alist_pkg::t_action'(i_in_word.action))
                        alist_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_rval  = '0;
                            n_state = alist_pkg::S_EMIT;
                        end
                        alist_pkg::ACT_INSERT: begin
                            if (r_count >= alist_pkg::CNT_W'(alist_pkg::DEPTH)) begin
                                n_st    = alist_pkg::ST_FULL;
                                n_state = alist_pkg::S_EMIT;
                            end else if (i_in_word.item_position > r_count) begin
                                n_st    = alist_pkg::ST_BADPOS;
                                n_state = alist_pkg::S_EMIT;
                            end else begin
                                n_idx   = r_count;
                                n_rpos  = i_in_word.item_position[alist_pkg::IDX_W-1:0];
                                n_state = (i_in_word.item_position == r_count) ?
                                          alist_pkg::S_INS_WR : alist_pkg::S_UP_RD;
                            end
                        end
                        alist_pkg::ACT_DEL_POS: begin
                            if (r_count == '0) begin
                                n_st    = alist_pkg::ST_EMPTY;
                                n_state = alist_pkg::S_EMIT;
                            end else if (i_in_word.item_position >= r_count) begin
                                n_st    = alist_pkg::ST_BADPOS;
                                n_state = alist_pkg::S_EMIT;
                            end else begin
                                n_idx   = i_in_word.item_position;
                                n_rpos  = i_in_word.item_position[alist_pkg::IDX_W-1:0];
                                n_state = alist_pkg::S_GET;
                            end
                        end
                        alist_pkg::ACT_DEL_VAL,
                        alist_pkg::ACT_SEARCH,
                        alist_pkg::ACT_DISPLAY: begin
                            if (r_count == '0) begin
                                n_st    = alist_pkg::ST_EMPTY;
                                n_state = alist_pkg::S_EMIT;
                            end else begin
                                n_state = alist_pkg::S_SC_RD;
                            end
                        end
                        default: begin
                            n_state = alist_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            alist_pkg::S_UP_RD: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = idx_dn[alist_pkg::IDX_W-1:0];
                n_state         = alist_pkg::S_UP_WR;
            end

            alist_pkg::S_UP_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_idx[alist_pkg::IDX_W-1:0];
                o_ram_req.wdata = i_ram_rdata;
                n_idx           = idx_dn;
                n_state         = (idx_dn == r_pos) ? alist_pkg::S_INS_WR : alist_pkg::S_UP_RD;
            end

            alist_pkg::S_INS_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_pos[alist_pkg::IDX_W-1:0];
                o_ram_req.wdata = r_val;
                n_count         = r_count + alist_pkg::CNT_W'(1);
                n_state         = alist_pkg::S_EMIT;
            end

            alist_pkg::S_GET: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_idx[alist_pkg::IDX_W-1:0];
                n_state         = alist_pkg::S_GOT;
            end

            alist_pkg::S_GOT: begin
                n_rval  = i_ram_rdata;
                n_state = alist_pkg::S_DN_RD;
            end

            alist_pkg::S_DN_RD: begin
                if (idx_up < r_count) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = idx_up[alist_pkg::IDX_W-1:0];
                    n_state         = alist_pkg::S_DN_WR;
                end else begin
                    n_count = r_count - alist_pkg::CNT_W'(1);
                    n_state = alist_pkg::S_EMIT;
                end
            end

            alist_pkg::S_DN_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_idx[alist_pkg::IDX_W-1:0];
                o_ram_req.wdata = i_ram_rdata;
                n_idx           = idx_up;
                n_state         = alist_pkg::S_DN_RD;
            end

            alist_pkg::S_SC_RD: begin
                if (r_idx < r_count) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_idx[alist_pkg::IDX_W-1:0];
                    n_state         = alist_pkg::S_SC_CMP;
                end else begin
                    if (r_act == alist_pkg::ACT_SEARCH && r_pend) begin
                        n_rpos = r_pend_pos;
                    end else begin
                        n_st = alist_pkg::ST_NOTFOUND;
                    end
                    n_state = alist_pkg::S_EMIT;
                end
            end

            alist_pkg::S_SC_CMP: begin
                case (alist_pkg::t_action'(r_act))
                    alist_pkg::ACT_DISPLAY: begin
                        if (i_slot_free) begin
                            o_emit                     = 1'b1;
                            o_emit_word.status         = alist_pkg::ST_OK;
                            o_emit_word.found_position = r_idx[alist_pkg::IDX_W-1:0];
                            o_emit_word.entry_value    = i_ram_rdata;
                            o_emit_word.fill_count     = r_count;
                            o_emit_word.last           = disp_last;
                            n_idx                      = idx_up;
                            n_state = disp_last ? alist_pkg::S_IDLE : alist_pkg::S_SC_RD;
                        end
                    end
                    alist_pkg::ACT_DEL_VAL: begin
                        if (hit) begin
                            n_rpos  = r_idx[alist_pkg::IDX_W-1:0];
                            n_state = alist_pkg::S_DN_RD;
                        end else begin
                            n_idx   = idx_up;
                            n_state = alist_pkg::S_SC_RD;
                        end
                    end
                    default: begin
                        if (!hit) begin
                            n_idx   = idx_up;
                            n_state = alist_pkg::S_SC_RD;
                        end else if (!r_pend || i_slot_free) begin
                            o_emit                     = r_pend;
                            o_emit_word.status         = alist_pkg::ST_OK;
                            o_emit_word.found_position = r_pend_pos;
                            o_emit_word.entry_value    = r_val;
                            o_emit_word.fill_count     = r_count;
                            o_emit_word.last           = 1'b0;
                            n_pend                     = 1'b1;
                            n_pend_pos                 = r_idx[alist_pkg::IDX_W-1:0];
                            n_idx                      = idx_up;
                            n_state                    = alist_pkg::S_SC_RD;
                        end
                    end
                endcase
            end

            alist_pkg::S_EMIT: begin
                if (i_slot_free) begin
                    o_emit                     = 1'b1;
                    o_emit_word.status         = r_st;
                    o_emit_word.found_position = r_rpos;
                    o_emit_word.entry_value    = r_rval;
                    o_emit_word.fill_count     = r_count;
                    o_emit_word.last           = 1'b1;
                    n_state                    = alist_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = alist_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/array_list_insert_delete_search.sv
`timescale 1ns / 1ps

// Channel   Valid          Ready          Word
// input     i_in_valid     o_in_ready     i_in_word   (action, item_value, item_position)
// output    o_out_valid    i_out_ready    o_out_word  (status, found_position, entry_value,
//                                                       fill_count, last)
//
// One word at a time; the entry store is a single-port-read RAM, so each entry moved or
// examined takes a read, then a write or a compare.
// Insert and delete by position move the entries between the position and the end;
// search, delete by value and display walk the list from the front, and output stalls hold them.
// Clear and error cases go straight to the result word; unused action codes return to idle.
// Synchronous active-low reset empties the list; the store needs no clearing pass.
// The output register holds a result while the sequencer carries on with the next entry.

module array_list_insert_delete_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  alist_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output alist_pkg::t_out_word o_out_word
);

    alist_pkg::t_ram_req         ram_req;
    logic [alist_pkg::VAL_W-1:0] ram_rdata;
    logic                        slot_free;
    logic                        emit;
    alist_pkg::t_out_word        emit_word;

    logic                        r_out_valid, n_out_valid;
    alist_pkg::t_out_word        r_out_word, n_out_word;

    alist_ram #(
        .WIDTH (alist_pkg::VAL_W),
        .DEPTH (alist_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    alist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .i_slot_free (slot_free),
        .o_emit      (emit),
        .o_emit_word (emit_word),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_word  = emit_word;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import alist_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int RANDOM_WORDS = 185;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 40;

    class alist_board;
        logic [VAL_W-1:0] entries [DEPTH];
        int unsigned fill;
        t_out_word expected_q[$];
        int errors;
        int words_in;
        int words_out;
        int peak_fill;
        int status_hits [5];

        function new();
            fill = 0;
            errors = 0;
            words_in = 0;
            words_out = 0;
            peak_fill = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function int unsigned count();
            return fill;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [VAL_W-1:0] stored_value();
            return entries[$urandom_range(0, fill - 1)];
        endfunction

        function void push_result(t_status st, int pos, logic [VAL_W-1:0] val, logic lst);
            t_out_word r;
            r.status = st;
            r.found_position = pos[IDX_W-1:0];
            r.entry_value = val;
            r.fill_count = fill[CNT_W-1:0];
            r.last = lst;
            expected_q.push_back(r);
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i + 1 < int'(fill); i++) entries[i] = entries[i + 1];
            fill--;
        endfunction

        function void note_word(t_in_word w);
            int pos;
            int idx;
            int hits;
            int k;
            logic [VAL_W-1:0] val;
            logic [VAL_W-1:0] old;
            pos = int'(w.item_position);
            val = w.item_value;
            idx = -1;
            hits = 0;
            k = 0;
            words_in++;
            case (w.action)
                ACT_CLEAR: begin
                    fill = 0;
                    push_result(ST_OK, 0, '0, 1'b1);
                end
                ACT_INSERT: begin
                    if (fill >= DEPTH) begin
                        push_result(ST_FULL, 0, val, 1'b1);
                    end else if (pos > int'(fill)) begin
                        push_result(ST_BADPOS, 0, val, 1'b1);
                    end else begin
                        for (int i = int'(fill); i > pos; i--) entries[i] = entries[i - 1];
                        entries[pos] = val;
                        fill++;
                        push_result(ST_OK, pos, val, 1'b1);
                    end
                end
                ACT_DEL_POS: begin
                    if (fill == 0) begin
                        push_result(ST_EMPTY, 0, val, 1'b1);
                    end else if (pos >= int'(fill)) begin
                        push_result(ST_BADPOS, 0, val, 1'b1);
                    end else begin
                        old = entries[pos];
                        remove_at(pos);
                        push_result(ST_OK, pos, old, 1'b1);
                    end
                end
                ACT_DEL_VAL: begin
                    if (fill == 0) begin
                        push_result(ST_EMPTY, 0, val, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(fill); i++)
                            if (idx < 0 && entries[i] == val) idx = i;
                        if (idx >= 0) begin
                            remove_at(idx);
                            push_result(ST_OK, idx, val, 1'b1);
                        end else begin
                            push_result(ST_NOTFOUND, 0, val, 1'b1);
                        end
                    end
                end
                ACT_SEARCH: begin
                    if (fill == 0) begin
                        push_result(ST_EMPTY, 0, val, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(fill); i++)
                            if (entries[i] == val) hits++;
                        if (hits == 0) push_result(ST_NOTFOUND, 0, val, 1'b1);
                        for (int i = 0; i < int'(fill); i++) begin
                            if (entries[i] == val) begin
                                k++;
                                push_result(ST_OK, i, val, k == hits);
                            end
                        end
                    end
                end
                ACT_DISPLAY: begin
                    if (fill == 0) begin
                        push_result(ST_EMPTY, 0, val, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(fill); i++)
                            push_result(ST_OK, i, entries[i], i + 1 == int'(fill));
                    end
                end
                default: ;
            endcase
            if (int'(fill) > peak_fill) peak_fill = int'(fill);
        endfunction

        function void match_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word exp_w;
            words_out++;
            if (expected_q.size() == 0) begin
                $error("unexpected output word: status %0d value %0d", got.status,
                       got.entry_value);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (exp_w.status < 5) status_hits[exp_w.status]++;
            match_field("status", exp_w.status, got.status);
            match_field("found_position", exp_w.found_position, got.found_position);
            match_field("entry_value", exp_w.entry_value, got.entry_value);
            match_field("fill_count", exp_w.fill_count, got.fill_count);
            match_field("last", exp_w.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in_word in_word;
    logic out_valid;
    logic out_ready;
    t_out_word out_word;

    alist_board board;
    int burst_left;
    int hold_left;
    bit hold_done;
    int ready_mode;
    int phase_left;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    array_list_insert_delete_search i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] pool [8];
        pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'd42, 32'hFFFF_FFD6};
        if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic offer(input logic [2:0] act, input logic [VAL_W-1:0] val, input int pos);
        t_in_word w;
        w.action = act;
        w.item_value = val;
        w.item_position = pos[CNT_W-1:0];
        pace();
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) board.check_word(out_word);
            if (!hold_done && board.words_out >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                case (ready_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 9) < 7);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #20_000_000;
        $display("[array_list_insert_delete_search] ERROR");
        $finish;
    end

    initial begin
        int sent;
        int r;
        int cnt;
        int full_tries;
        bit growing;
        logic [2:0] act;
        logic [VAL_W-1:0] val;
        int pos;

        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        burst_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        ready_mode = 0;
        phase_left = 0;
        sent = 0;
        full_tries = 0;
        growing = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(ACT_DISPLAY, 32'h0, 0);
        offer(ACT_SEARCH, 32'd5, 0);
        offer(ACT_DEL_POS, 32'd5, 0);
        offer(ACT_DEL_VAL, 32'd5, 0);
        offer(ACT_INSERT, 32'd9, 1);
        offer(ACT_INSERT, 32'h7FFF_FFFF, 0);
        offer(ACT_INSERT, 32'h8000_0000, 0);
        offer(ACT_INSERT, 32'hFFFF_FFFF, 2);
        offer(ACT_INSERT, 32'h7FFF_FFFF, 1);
        offer(ACT_INSERT, 32'h0, DEPTH);
        offer(ACT_SPARE_A, $urandom, $urandom_range(0, DEPTH));
        offer(ACT_SPARE_B, $urandom, $urandom_range(0, DEPTH));
        offer(ACT_SEARCH, 32'h7FFF_FFFF, 0);
        offer(ACT_SEARCH, 32'd12345, 0);
        offer(ACT_DISPLAY, 32'h0, 0);
        offer(ACT_DEL_VAL, 32'hFFFF_FFFF, 0);
        offer(ACT_DEL_VAL, 32'd999, 0);
        offer(ACT_DEL_POS, 32'h0, 3);
        offer(ACT_DEL_POS, 32'h0, DEPTH);
        offer(ACT_DEL_POS, 32'h0, 0);
        offer(ACT_DISPLAY, 32'h0, 0);
        offer(ACT_CLEAR, 32'h0, 0);
        offer(ACT_DISPLAY, 32'h0, 0);
        drain();

        while (sent < RANDOM_WORDS) begin
            cnt = int'(board.count());
            if (growing && cnt == DEPTH) begin
                full_tries++;
                if (full_tries > 3) growing = 1'b0;
            end
            if (!growing && cnt == 0) begin
                growing = 1'b1;
                full_tries = 0;
            end
            r = $urandom_range(0, 99);
            if (growing)
                act = (r < 70) ? ACT_INSERT : (r < 76) ? ACT_DEL_POS :
                      (r < 82) ? ACT_DEL_VAL : (r < 92) ? ACT_SEARCH :
                      (r < 96) ? ACT_DISPLAY : (r < 98) ? ACT_SPARE_A : ACT_SPARE_B;
            else
                act = (r < 12) ? ACT_INSERT : (r < 45) ? ACT_DEL_POS :
                      (r < 70) ? ACT_DEL_VAL : (r < 82) ? ACT_SEARCH :
                      (r < 90) ? ACT_DISPLAY : (r < 94) ? ACT_CLEAR :
                      (r < 97) ? ACT_SPARE_A : ACT_SPARE_B;
            val = pick_value();
            pos = $urandom_range(0, DEPTH);
            case (act)
                ACT_INSERT: begin
                    if ($urandom_range(0, 9) < 9 || cnt == DEPTH) pos = $urandom_range(0, cnt);
                    else pos = $urandom_range(cnt + 1, DEPTH);
                end
                ACT_DEL_POS: begin
                    if (cnt > 0 && $urandom_range(0, 9) < 9) pos = $urandom_range(0, cnt - 1);
                    else pos = $urandom_range(cnt, DEPTH);
                end
                ACT_DEL_VAL, ACT_SEARCH: begin
                    if (cnt > 0 && $urandom_range(0, 9) < 7) val = board.stored_value();
                end
                default: ;
            endcase
            offer(act, val, pos);
            if (act != ACT_SPARE_A && act != ACT_SPARE_B) sent++;
            if (sent == RANDOM_WORDS / 2) drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d words in and %0d words out, list filled up to %0d of %0d",
                 board.words_in, board.words_out, board.peak_fill, DEPTH);
        $display("status words: full %0d, empty %0d, bad position %0d, not found %0d",
                 board.status_hits[ST_FULL], board.status_hits[ST_EMPTY],
                 board.status_hits[ST_BADPOS], board.status_hits[ST_NOTFOUND]);
        if (board.errors == 0 && board.pending() == 0)
            $display("[array_list_insert_delete_search] OK");
        else
            $display("[array_list_insert_delete_search] ERROR");
        $finish;
    end

endmodule

// File: array_list_insert_delete_search.f
src/alist_pkg.sv
src/alist_ram.sv
src/alist_ctrl.sv
src/array_list_insert_delete_search.sv
tb/sv/tb.sv
